FILE: hdl/box_blur_3x3_stream_macros.svh
// ----------------------------------------------------------------------------
// Box blur assertion macros
// Shorthand for the concurrent checks of the box blur block. They use the
// clock clk and the active-low reset arst_n of the module they stand in.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_STREAM_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BB33_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box blur check failed");

// Consequent must hold in the cycle after the antecedent.
`define BB33_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box blur check failed");

`endif

FILE: hdl/bb33_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Shared widths, register indexes, pixel and pipeline types, and the
// reciprocal constants of the neighborhood mean.
// ----------------------------------------------------------------------------
package bb33_pkg;

	localparam int CH_W           = 8;
	localparam int ROW_W          = 12;
	localparam int COL_W          = 10;
	localparam int SUM_W          = 12;
	localparam int CFG_INDEX_W    = 8;
	localparam int CFG_DATA_W     = 13;
	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;

	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 8'd0,
		REG_FRAME_HEIGHT = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	// One accepted pixel with its position and the edge facts that select
	// which outputs it completes and which neighbors those outputs see.
	typedef struct packed {
		pixel_t           pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             row_ge1;
		logic             row_ge2;
		logic             row_last;
		logic             col_ge1;
		logic             col_ge2;
		logic             col_last;
	} item_t;

	// Number of in-bounds neighbors.
	typedef enum logic [1:0] {
		CNT_4 = 2'd0,
		CNT_6 = 2'd1,
		CNT_9 = 2'd2
	} cnt_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		cnt_t             cnt;
		logic             last;
	} sum_t;

	// (2*s + n) / (2*n) is taken as ((2*s + n) * RECIP) >> RECIP_SHIFT, with
	// RECIP = ceil(2^RECIP_SHIFT / (2*n)); exact for every sum of 9 bytes.
	localparam int          RECIP_SHIFT = 20;
	localparam logic [17:0] RECIP_4     = 18'd131072;
	localparam logic [17:0] RECIP_6     = 18'd87382;
	localparam logic [17:0] RECIP_9     = 18'd58255;

endpackage

FILE: hdl/bb33_pix_if.sv
// ----------------------------------------------------------------------------
// Box blur pixel channel
// Valid/ready channel carrying one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface bb33_pix_if;
	logic                      valid;
	logic                      ready;
	logic [bb33_pkg::CH_W-1:0] in_red;
	logic [bb33_pkg::CH_W-1:0] in_green;
	logic [bb33_pkg::CH_W-1:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

FILE: hdl/bb33_res_if.sv
// ----------------------------------------------------------------------------
// Box blur result channel
// Valid/ready channel carrying one blurred pixel with its position per beat.
// ----------------------------------------------------------------------------
interface bb33_res_if;
	logic                       valid;
	logic                       ready;
	logic [bb33_pkg::ROW_W-1:0] out_row;
	logic [bb33_pkg::COL_W-1:0] out_col;
	logic [bb33_pkg::CH_W-1:0]  out_red;
	logic [bb33_pkg::CH_W-1:0]  out_green;
	logic [bb33_pkg::CH_W-1:0]  out_blue;
	logic                       run_last;

	modport source (output valid, output out_row, output out_col, output out_red,
		output out_green, output out_blue, output run_last, input ready);
	modport sink (input valid, input out_row, input out_col, input out_red,
		input out_green, input out_blue, input run_last, output ready);
endinterface

FILE: hdl/bb33_cfg_if.sv
// ----------------------------------------------------------------------------
// Box blur configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bb33_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bb33_pkg::CFG_INDEX_W-1:0] index;
	logic [bb33_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/box_blur_3x3_stream.sv
// ----------------------------------------------------------------------------
// Streaming 3x3 box blur
// Raster-order RGB pixels in, rounded 3x3 neighborhood means out, each tagged
// with its row and column; two line buffers keep the previous two rows.
//
//   channel  role    beat carries
//   -------  ------  ---------------------------------------------------
//   cfg      sink    register index and data (frame width, frame height)
//   pix      sink    one pixel: in_red, in_green, in_blue
//   res      source  out_row, out_col, out_red/green/blue, run_last
//
// A pixel beat is taken every cycle while each pixel completes at most one
// output and res does not stall; the window stage emits its outputs in turn,
// so the last pixel of a row below the first and every pixel but the first of
// the last row complete two outputs each, the bottom-right corner four.
// A taken pixel's result passes the window, sum and output registers in turn.
// Reset clears control and counters only; the line buffers need no clearing.
// A stalled res channel backs up through the stages to pix.ready.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_stream_macros.svh"

module box_blur_3x3_stream #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	bb33_cfg_if.sink   cfg,
	bb33_pix_if.sink   pix,
	bb33_res_if.source res
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int ROW_W = bb33_pkg::ROW_W;
	localparam int COL_W = bb33_pkg::COL_W;

	logic [bb33_pkg::FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [bb33_pkg::FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [CW-1:0]                       col_q;
	logic [RW-1:0]                       row_q;
	logic                                s1_valid_q;
	bb33_pkg::item_t                     s1_item_q;
	logic [CW-1:0]                       s1_addr_q;

	logic [31:0]      fw;
	logic [31:0]      fh;
	logic [31:0]      wl32;
	logic [31:0]      hl32;
	logic [CW-1:0]    w_last;
	logic [RW-1:0]    h_last;
	logic [CW-1:0]    col_cur;
	logic [RW-1:0]    row_cur;
	logic             accept;
	logic             cfg_we;
	logic             frame_we;
	logic             item_take;
	bb33_pkg::item_t  new_item;
	bb33_pkg::pixel_t older_pix;
	bb33_pkg::pixel_t newer_pix;
	logic             sum_valid;
	logic             sum_ready;
	bb33_pkg::sum_t   sum;

	// Last column and row of the frame, sizes clamped to 2..MAX.
	always_comb begin
		fw = 32'(frame_width_q);
		fh = 32'(frame_height_q);
		if (fw < 32'd2) begin
			wl32 = 32'd1;
		end else if (fw > 32'(MAX_WIDTH)) begin
			wl32 = 32'(MAX_WIDTH) - 32'd1;
		end else begin
			wl32 = fw - 32'd1;
		end
		if (fh < 32'd2) begin
			hl32 = 32'd1;
		end else if (fh > 32'(MAX_HEIGHT)) begin
			hl32 = 32'(MAX_HEIGHT) - 32'd1;
		end else begin
			hl32 = fh - 32'd1;
		end
	end

	assign w_last  = CW'(wl32);
	assign h_last  = RW'(hl32);
	assign col_cur = (col_q > w_last) ? '0 : col_q;
	assign row_cur = (row_q > h_last) ? '0 : row_q;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign frame_we  = cfg_we && (cfg.index == bb33_pkg::REG_FRAME_WIDTH
		|| cfg.index == bb33_pkg::REG_FRAME_HEIGHT);

	assign pix.ready = !s1_valid_q || item_take;
	assign accept    = pix.valid && pix.ready;

	always_comb begin
		new_item.pix.red   = pix.in_red;
		new_item.pix.green = pix.in_green;
		new_item.pix.blue  = pix.in_blue;
		new_item.row       = ROW_W'(row_cur);
		new_item.col       = COL_W'(col_cur);
		new_item.row_ge1   = row_cur != '0;
		new_item.row_ge2   = 32'(row_cur) >= 32'd2;
		new_item.row_last  = row_cur == h_last;
		new_item.col_ge1   = col_cur != '0;
		new_item.col_ge2   = 32'(col_cur) >= 32'd2;
		new_item.col_last  = col_cur == w_last;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_item_q <= new_item;
			s1_addr_q <= col_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= bb33_pkg::FRAME_WIDTH_RST;
			frame_height_q <= bb33_pkg::FRAME_HEIGHT_RST;
			col_q          <= '0;
			row_q          <= '0;
			s1_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (item_take) begin
				s1_valid_q <= 1'b0;
			end
			if (accept) begin
				if (col_cur == w_last) begin
					col_q <= '0;
					row_q <= (row_cur == h_last) ? '0 : row_cur + RW'(1);
				end else begin
					col_q <= col_cur + CW'(1);
				end
			end
			// A frame size write starts a new image with the next pixel.
			if (frame_we) begin
				col_q <= '0;
				row_q <= '0;
			end
			if (cfg_we) begin
				case (cfg.index)
					bb33_pkg::REG_FRAME_WIDTH:
						frame_width_q <= cfg.data[bb33_pkg::FRAME_WIDTH_W-1:0];
					bb33_pkg::REG_FRAME_HEIGHT:
						frame_height_q <= cfg.data[bb33_pkg::FRAME_HEIGHT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	bb33_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_lbuf (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (col_cur),
		.wr_en    (item_take),
		.wr_addr  (s1_addr_q),
		.wr_pix   (s1_item_q.pix),
		.older_rd (older_pix),
		.newer_rd (newer_pix)
	);

	bb33_window u_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s1_valid_q),
		.item       (s1_item_q),
		.older_pix  (older_pix),
		.newer_pix  (newer_pix),
		.item_take  (item_take),
		.sum_valid  (sum_valid),
		.sum        (sum),
		.sum_ready  (sum_ready)
	);

	bb33_divide u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.sum       (sum),
		.sum_ready (sum_ready),
		.res       (res)
	);

	`BB33_ASSERT(a_pos_in_frame, 1'b1, (col_q <= w_last) && (row_q <= h_last))
	`BB33_ASSERT_NEXT(a_size_write_restarts, frame_we, (col_q == '0) && (row_q == '0))
	`BB33_ASSERT_NEXT(a_s1_holds, s1_valid_q && !item_take, s1_valid_q && $stable(s1_addr_q))

endmodule

FILE: hdl/bb33_line_buf.sv
// ----------------------------------------------------------------------------
// Box blur line buffers
// Two row memories holding the previous two image rows. Each column is read
// when its pixel is accepted and rewritten when that pixel leaves the input
// stage: the older row takes the newer row's word, the newer row the pixel.
// ----------------------------------------------------------------------------
module bb33_line_buf #(
	parameter int DEPTH = 1024
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                    wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  bb33_pkg::pixel_t        wr_pix,
	output bb33_pkg::pixel_t        older_rd,
	output bb33_pkg::pixel_t        newer_rd
);

	bb33_pkg::pixel_t older_mem [DEPTH];
	bb33_pkg::pixel_t newer_mem [DEPTH];
	bb33_pkg::pixel_t older_rd_q;
	bb33_pkg::pixel_t newer_rd_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			older_rd_q <= older_mem[rd_addr];
			newer_rd_q <= newer_mem[rd_addr];
		end
		// The read word of this column is still in newer_rd_q here.
		if (wr_en) begin
			older_mem[wr_addr] <= newer_rd_q;
			newer_mem[wr_addr] <= wr_pix;
		end
	end

	assign older_rd = older_rd_q;
	assign newer_rd = newer_rd_q;

endmodule

FILE: hdl/bb33_window.sv
// ----------------------------------------------------------------------------
// Box blur window and neighborhood sums
// Holds the 3x3 window, steps through the zero, one, two or four outputs that
// the newest pixel completes, and registers the masked channel sums of each.
// ----------------------------------------------------------------------------
module bb33_window (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  bb33_pkg::item_t  item,
	input  bb33_pkg::pixel_t older_pix,
	input  bb33_pkg::pixel_t newer_pix,
	output logic             item_take,
	output logic             sum_valid,
	output bb33_pkg::sum_t   sum,
	input  logic             sum_ready
);

	localparam int SUM_W = bb33_pkg::SUM_W;
	localparam int ROW_W = bb33_pkg::ROW_W;
	localparam int COL_W = bb33_pkg::COL_W;

	bb33_pkg::pixel_t win_q [9];
	bb33_pkg::item_t  s2_q;
	logic             s2_valid_q;
	logic             cr2_q;
	logic             cc2_q;
	bb33_pkg::sum_t   s3_q;
	logic             s3_valid_q;

	logic             s3_free;
	logic             emit;
	logic             more;
	logic             s2_free;
	logic             rk0;
	logic             ck0;
	logic [SUM_W-1:0] rs_red [3];
	logic [SUM_W-1:0] rs_green [3];
	logic [SUM_W-1:0] rs_blue [3];
	bb33_pkg::sum_t   next_sum;

	assign s3_free   = !s3_valid_q || sum_ready;
	assign emit      = s2_valid_q && s3_free;
	// cr2_q/cc2_q select the lower row or right column of the output pair.
	assign more      = (!cc2_q && s2_q.col_last) || (!cr2_q && s2_q.row_last);
	assign s2_free   = !s2_valid_q || (emit && !more);
	assign item_take = item_valid && s2_free;

	// The top window row and left window column are only inside the image for
	// the upper-left output and only away from the first two rows or columns.
	assign rk0 = !cr2_q && s2_q.row_ge2;
	assign ck0 = !cc2_q && s2_q.col_ge2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rs_red[k] = (ck0 ? SUM_W'(win_q[3*k].red) : '0)
				+ SUM_W'(win_q[3*k+1].red) + SUM_W'(win_q[3*k+2].red);
			rs_green[k] = (ck0 ? SUM_W'(win_q[3*k].green) : '0)
				+ SUM_W'(win_q[3*k+1].green) + SUM_W'(win_q[3*k+2].green);
			rs_blue[k] = (ck0 ? SUM_W'(win_q[3*k].blue) : '0)
				+ SUM_W'(win_q[3*k+1].blue) + SUM_W'(win_q[3*k+2].blue);
		end
		next_sum.sum_red   = (rk0 ? rs_red[0] : '0) + rs_red[1] + rs_red[2];
		next_sum.sum_green = (rk0 ? rs_green[0] : '0) + rs_green[1] + rs_green[2];
		next_sum.sum_blue  = (rk0 ? rs_blue[0] : '0) + rs_blue[1] + rs_blue[2];
		case ({rk0, ck0})
			2'b11: next_sum.cnt = bb33_pkg::CNT_9;
			2'b00: next_sum.cnt = bb33_pkg::CNT_4;
			default: next_sum.cnt = bb33_pkg::CNT_6;
		endcase
		next_sum.row  = cr2_q ? s2_q.row : s2_q.row - ROW_W'(1);
		next_sum.col  = cc2_q ? s2_q.col : s2_q.col - COL_W'(1);
		next_sum.last = !more;
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			for (int k = 0; k < 3; k++) begin
				win_q[3*k]   <= win_q[3*k+1];
				win_q[3*k+1] <= win_q[3*k+2];
			end
			win_q[2] <= older_pix;
			win_q[5] <= newer_pix;
			win_q[8] <= item.pix;
			s2_q     <= item;
		end
		if (emit) begin
			s3_q <= next_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			cr2_q      <= 1'b0;
			cc2_q      <= 1'b0;
			s3_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				s2_valid_q <= (item.row_ge1 || item.row_last)
					&& (item.col_ge1 || item.col_last);
				cr2_q <= !item.row_ge1;
				cc2_q <= !item.col_ge1;
			end else if (emit) begin
				if (more) begin
					if (!cc2_q && s2_q.col_last) begin
						cc2_q <= 1'b1;
					end else begin
						cr2_q <= 1'b1;
						cc2_q <= !s2_q.col_ge1;
					end
				end else begin
					s2_valid_q <= 1'b0;
				end
			end
			if (emit) begin
				s3_valid_q <= 1'b1;
			end else if (sum_ready) begin
				s3_valid_q <= 1'b0;
			end
		end
	end

	assign sum_valid = s3_valid_q;
	assign sum       = s3_q;

endmodule

FILE: hdl/bb33_divide.sv
// ----------------------------------------------------------------------------
// Box blur mean and output register
// Turns each channel sum into its rounded mean by a reciprocal multiply and
// holds the result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module bb33_divide (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sum_valid,
	input  bb33_pkg::sum_t sum,
	output logic           sum_ready,
	bb33_res_if.source     res
);

	localparam int SUM_W = bb33_pkg::SUM_W;
	localparam int CH_W  = bb33_pkg::CH_W;

	logic                       ov_q;
	logic [bb33_pkg::ROW_W-1:0] row_q;
	logic [bb33_pkg::COL_W-1:0] col_q;
	logic [CH_W-1:0]            red_q;
	logic [CH_W-1:0]            green_q;
	logic [CH_W-1:0]            blue_q;
	logic                       last_q;
	logic                       take;

	function automatic logic [CH_W-1:0] mean(input logic [SUM_W-1:0] s,
		input bb33_pkg::cnt_t cnt);
		logic [3:0]       n;
		logic [17:0]      m;
		logic [SUM_W:0]   y;
		logic [30:0]      p;
		case (cnt)
			bb33_pkg::CNT_4: begin
				n = 4'd4;
				m = bb33_pkg::RECIP_4;
			end
			bb33_pkg::CNT_6: begin
				n = 4'd6;
				m = bb33_pkg::RECIP_6;
			end
			bb33_pkg::CNT_9: begin
				n = 4'd9;
				m = bb33_pkg::RECIP_9;
			end
			default: begin
				n = 4'd4;
				m = bb33_pkg::RECIP_4;
			end
		endcase
		y = {s, 1'b0} + (SUM_W+1)'(n);
		p = 31'(y) * 31'(m);
		return p[bb33_pkg::RECIP_SHIFT +: CH_W];
	endfunction

	assign sum_ready = !ov_q || res.ready;
	assign take      = sum_valid && sum_ready;

	always_ff @(posedge clk) begin
		if (take) begin
			row_q   <= sum.row;
			col_q   <= sum.col;
			red_q   <= mean(sum.sum_red, sum.cnt);
			green_q <= mean(sum.sum_green, sum.cnt);
			blue_q  <= mean(sum.sum_blue, sum.cnt);
			last_q  <= sum.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (take) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	assign res.valid     = ov_q;
	assign res.out_row   = row_q;
	assign res.out_col   = col_q;
	assign res.out_red   = red_q;
	assign res.out_green = green_q;
	assign res.out_blue  = blue_q;
	assign res.run_last  = last_q;

endmodule
